// ----- rtl/occupancy_grid_cell_update_defines.svh -----
// Assertion macros shared by the occupancy grid checker.
`ifndef OCCUPANCY_GRID_CELL_UPDATE_DEFINES_SVH
`define OCCUPANCY_GRID_CELL_UPDATE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OGCU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OGCU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ogcu_pkg.sv -----
// Types and constants shared by the occupancy grid cell update block.
`default_nettype none

package ogcu_pkg;

  localparam logic [2:0] FUNC_SET      = 3'd0;
  localparam logic [2:0] FUNC_CHANGE   = 3'd1;
  localparam logic [2:0] FUNC_GET      = 3'd2;
  localparam logic [2:0] FUNC_OPEN     = 3'd3;
  localparam logic [2:0] FUNC_CLOSE    = 3'd4;
  localparam logic [2:0] FUNC_THR_OPEN = 3'd5;

  localparam logic [2:0] CFG_SAT_LIMIT      = 3'd0;
  localparam logic [2:0] CFG_OPEN_STEP      = 3'd1;
  localparam logic [2:0] CFG_OPEN_CEIL      = 3'd2;
  localparam logic [2:0] CFG_CLOSE_STEP     = 3'd3;
  localparam logic [2:0] CFG_CLOSE_MIN      = 3'd4;
  localparam logic [2:0] CFG_FREE_THRESHOLD = 3'd5;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [7:0]  value;
  } ogcu_in_t;

  typedef struct packed {
    logic signed [7:0] cell_value;
    logic              was_free;
    logic              bad_coord;
  } ogcu_out_t;

  typedef struct packed {
    logic [6:0]        sat_limit;
    logic [6:0]        open_step;
    logic signed [7:0] open_ceil;
    logic signed [7:0] close_step;
    logic signed [7:0] close_min;
    logic signed [7:0] free_threshold;
  } ogcu_cfg_t;

  typedef struct packed {
    logic       we;
    logic [7:0] wdata;
    ogcu_out_t  rsp;
  } ogcu_upd_t;

  localparam ogcu_cfg_t CFG_RESET = '{
    sat_limit:      7'd127,
    open_step:      7'd1,
    open_ceil:      8'sd126,
    close_step:     -8'sd1,
    close_min:      -8'sd126,
    free_threshold: 8'sd0
  };

endpackage

`default_nettype wire

// ----- rtl/ogcu_mem.sv -----
// Cell store: one write port and one read port with registered read data.
`default_nettype none

module ogcu_mem #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ogcu_calc.sv -----
// Cell update arithmetic: new cell value, write enable and result fields.
`default_nettype none

module ogcu_calc
  import ogcu_pkg::*;
(
  input  wire logic [2:0]        func,
  input  wire logic signed [7:0] value,
  input  wire logic signed [7:0] cur,
  input  wire logic              coord_ok,
  input  wire ogcu_cfg_t         cfg,
  output ogcu_upd_t              upd
);

  localparam logic signed [9:0] CELL_MAX = 10'sd127;

  logic signed [9:0] cur_w;
  logic signed [9:0] val_w;
  logic signed [9:0] max_w;
  logic signed [9:0] neg_max_w;
  logic signed [9:0] chg_sum;
  logic signed [9:0] chg_res;
  logic signed [9:0] open_sum;
  logic signed [9:0] open_res;
  logic signed [9:0] close_sum;
  logic signed [9:0] close_res;

  assign cur_w     = 10'(cur);
  assign val_w     = 10'(value);
  assign max_w     = signed'({3'b000, cfg.sat_limit});
  assign neg_max_w = -max_w;
  assign chg_sum   = cur_w + val_w;
  assign open_sum  = cur_w + signed'({3'b000, cfg.open_step});
  assign close_sum = cur_w + 10'(cfg.close_step);

  always_comb begin
    if (val_w > 10'sd0) begin
      chg_res = (cur_w <= max_w - val_w) ? chg_sum : max_w;
    end else begin
      chg_res = (cur_w >= neg_max_w - val_w) ? chg_sum : neg_max_w;
    end

    if (cur <= cfg.open_ceil) begin
      open_res = (open_sum > max_w) ? max_w : open_sum;
    end else begin
      open_res = max_w;
    end

    if (cur >= cfg.close_min) begin
      if (close_sum < neg_max_w) begin
        close_res = neg_max_w;
      end else if (close_sum > CELL_MAX) begin
        close_res = CELL_MAX;
      end else begin
        close_res = close_sum;
      end
    end else begin
      close_res = neg_max_w;
    end
  end

  always_comb begin
    upd = '0;
    case (func)
      FUNC_SET: begin
        upd.we    = coord_ok;
        upd.wdata = value;
      end
      FUNC_CHANGE: begin
        upd.we    = coord_ok;
        upd.wdata = chg_res[7:0];
      end
      FUNC_GET: begin
        upd.rsp.cell_value = coord_ok ? cur : 8'sd0;
      end
      FUNC_OPEN: begin
        upd.we    = coord_ok;
        upd.wdata = open_res[7:0];
      end
      FUNC_CLOSE: begin
        upd.we    = coord_ok;
        upd.wdata = close_res[7:0];
      end
      FUNC_THR_OPEN: begin
        upd.we           = coord_ok;
        upd.wdata        = open_res[7:0];
        upd.rsp.was_free = coord_ok && (cur < cfg.free_threshold);
      end
      default: begin
        upd = '0;
      end
    endcase
    if ((func != FUNC_SET) && (func != FUNC_CHANGE) && (func != FUNC_GET) &&
        (func != FUNC_OPEN) && (func != FUNC_CLOSE) && (func != FUNC_THR_OPEN)) begin
      upd.rsp.bad_coord = 1'b0;
    end else begin
      upd.rsp.bad_coord = !coord_ok;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/occupancy_grid_cell_update.sv -----
// Top level of the occupancy grid cell update block.
//
// Requests arrive on req_valid/req_ready/req_data and carry an operation,
// signed cell coordinates and a value. Each request gives exactly one result
// on rsp_valid/rsp_ready/rsp_data, in request order.
// Configuration registers are written through cfg_valid/cfg_index/cfg_data;
// cfg_ready is always high, and writes are expected only while the block is idle.
// A request is accepted into a read stage while the cell store is read; in the
// stage after it the cell is updated, written back and the result is loaded into
// the output register, once that register is free.
// One request per cycle is sustained while the receiver takes results; a write to a cell is forwarded to a
// request for the same cell that follows directly behind it.
// After reset the cell store is cleared one cell per cycle, all GRID_DIM*GRID_DIM
// cells (65536 at the default size); req_ready stays low during that pass while
// configuration writes are still taken.
// When the receiver stalls, the output register and the read stage hold
// their requests; with the read stage full, req_ready stays low until the result is taken.
`default_nettype none

module occupancy_grid_cell_update
  import ogcu_pkg::*;
#(
  parameter int GRID_DIM = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_ready,
  input  wire ogcu_in_t   req_data,
  output logic            rsp_valid,
  input  wire logic       rsp_ready,
  output ogcu_out_t       rsp_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  localparam int DEPTH = GRID_DIM * GRID_DIM;
  localparam int CW    = $clog2(GRID_DIM);
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] DIM_A  = AW'(GRID_DIM);
  localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);
  localparam logic [14:0]   LIM    = 15'(GRID_DIM);

  ogcu_cfg_t cfg;

  logic          clear_busy;
  logic [AW-1:0] clear_addr;

  logic              s1_valid;
  logic [2:0]        s1_func;
  logic signed [7:0] s1_value;
  logic              s1_ok;
  logic [AW-1:0]     s1_addr;
  logic              fwd;
  logic [7:0]        fwd_data;

  logic          req_fire;
  logic          s1_fire;
  logic          req_ok;
  logic [AW-1:0] req_addr;
  logic [7:0]    rd_data;
  logic [7:0]    cur;
  ogcu_upd_t     upd;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  assign cfg_ready = 1'b1;

  assign req_ok   = !req_data.x[15] && (req_data.x[14:0] < LIM) &&
                    !req_data.y[15] && (req_data.y[14:0] < LIM);
  assign req_addr = AW'(AW'(req_data.y[CW-1:0]) * DIM_A) + AW'(req_data.x[CW-1:0]);

  assign s1_fire   = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !clear_busy && (!s1_valid || s1_fire);
  assign req_fire  = req_valid && req_ready;

  assign cur = fwd ? fwd_data : rd_data;

  assign mem_we    = clear_busy || (s1_fire && upd.we);
  assign mem_waddr = clear_busy ? clear_addr : s1_addr;
  assign mem_wdata = clear_busy ? 8'd0 : upd.wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SAT_LIMIT:      cfg.sat_limit      <= cfg_data[6:0];
        CFG_OPEN_STEP:      cfg.open_step      <= cfg_data[6:0];
        CFG_OPEN_CEIL:      cfg.open_ceil      <= cfg_data;
        CFG_CLOSE_STEP:     cfg.close_step     <= cfg_data;
        CFG_CLOSE_MIN:      cfg.close_min      <= cfg_data;
        CFG_FREE_THRESHOLD: cfg.free_threshold <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_busy <= 1'b1;
      clear_addr <= '0;
    end else if (clear_busy) begin
      clear_addr <= clear_addr + AW'(1);
      if (clear_addr == LAST_A) begin
        clear_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  // The memory read of a request and the write of the one ahead of it share
  // an edge; the written value is captured here for that case.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1_func  <= req_data.func;
      s1_value <= req_data.value;
      s1_ok    <= req_ok;
      s1_addr  <= req_addr;
      fwd      <= s1_fire && upd.we && (s1_addr == req_addr);
      fwd_data <= upd.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      rsp_data <= upd.rsp;
    end
  end

  ogcu_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (req_fire),
    .raddr (req_addr),
    .rdata (rd_data)
  );

  ogcu_calc u_calc (
    .func     (s1_func),
    .value    (s1_value),
    .cur      (cur),
    .coord_ok (s1_ok),
    .cfg      (cfg),
    .upd      (upd)
  );

endmodule

`default_nettype wire

// ----- rtl/ogcu_checker.sv -----
// Port-level checker for the occupancy grid cell update block, with its bind.
`default_nettype none

`include "occupancy_grid_cell_update_defines.svh"

module ogcu_checker
  import ogcu_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      req_valid,
  input wire logic      req_ready,
  input wire logic      rsp_valid,
  input wire logic      rsp_ready,
  input wire ogcu_out_t rsp_data
);

  // The store is being cleared right after reset, so no request is taken.
  `OGCU_ASSERT_NOW(a_no_req_after_rst, $past(rst), !req_ready, "request taken during clear")

  // A new result rises only after an accepted request has passed through the read stage.
  `OGCU_ASSERT_NOW(a_rsp_latency, $rose(rsp_valid), $past(req_valid && req_ready, 2), "result without request")

  // A rejected coordinate never reports a cell value or a free cell.
  `OGCU_ASSERT_NOW(a_bad_coord_clean, rsp_valid && rsp_data.bad_coord, (rsp_data.cell_value == 8'sd0) && !rsp_data.was_free, "bad coordinate with data")

  // A stalled result holds.
  `OGCU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")

endmodule

bind occupancy_grid_cell_update ogcu_checker u_ogcu_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp_data  (rsp_data)
);

`default_nettype wire
